@@ rtl/pip_pkg.sv @@
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 32;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int EPS_W        = 16;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int ACC_W        = 2 * DIFF_W + 2;
  localparam int ROOT_W       = ACC_W / 2;
  localparam int REM_W        = ROOT_W + 2;
  localparam int MUL_W        = ROOT_W + 1;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int NORM_BITS    = 30;
  localparam int CORD_STEPS   = 32;
  localparam int CRD_W        = NORM_BITS + 4;
  localparam int ANG_W        = NORM_BITS + 4;
  localparam int SUM_W        = ANG_W + ADDR_W;
  localparam int STEP_W       = 6;
  localparam int MUL_STEPS    = 14;
  localparam int EPS_SHIFT    = 14;

  localparam logic signed [SUM_W:0]   TWO_PI_Q30  = (SUM_W + 1)'(64'sd6746518852);
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(64'sd1686629713);

  localparam logic [3:0] SEL_EPS_ROOT = 4'd14;
  localparam logic [2:0] PAIR_A2  = 3'd0;
  localparam logic [2:0] PAIR_B2  = 3'd1;
  localparam logic [2:0] PAIR_UE  = 3'd2;
  localparam logic [2:0] PAIR_WE  = 3'd3;
  localparam logic [2:0] PAIR_CR  = 3'd4;
  localparam logic [2:0] PAIR_C2  = 3'd5;
  localparam logic [2:0] PAIR_DOT = 3'd6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_QSTART, OP_READ0, OP_READJ, OP_LDA, OP_LDB, OP_DIFF,
    OP_MUL, OP_SQRT_INIT, OP_SQRT, OP_MULC, OP_NORM_INIT, OP_NORM,
    OP_CORD_INIT, OP_CORD, OP_ACC, OP_RESULT
  } dp_op_t;

  typedef enum logic [1:0] {RES_NONE, RES_VERTEX, RES_EDGE, RES_SUM} res_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD0, ST_LDA, ST_RDJ, ST_LDB, ST_DIFF, ST_MUL, ST_VTEST,
    ST_SQRT_INIT, ST_SQRT, ST_MULC, ST_ETEST, ST_NORM_INIT, ST_NORM,
    ST_CORD_INIT, ST_CORD, ST_ACC, ST_OUT
  } state_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STEP_W-1:0] idx;
    res_kind_t         res;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic last_edge;
    logic vertex_hit;
    logic edge_hit;
    logic ang_zero;
    logic norm_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic [ANG_W-1:0] r;
    case (i)
      5'd0:  r = ANG_W'(32'h3243F6A8);
      5'd1:  r = ANG_W'(32'h1DAC6705);
      5'd2:  r = ANG_W'(32'h0FADBAFC);
      5'd3:  r = ANG_W'(32'h07F56EA6);
      5'd4:  r = ANG_W'(32'h03FEAB76);
      5'd5:  r = ANG_W'(32'h01FFD55B);
      5'd6:  r = ANG_W'(32'h00FFFAAA);
      5'd7:  r = ANG_W'(32'h007FFF55);
      5'd8:  r = ANG_W'(32'h003FFFEA);
      5'd9:  r = ANG_W'(32'h001FFFFD);
      5'd10: r = ANG_W'(32'h000FFFFF);
      5'd11: r = ANG_W'(32'h0007FFFF);
      5'd12: r = ANG_W'(32'h0003FFFF);
      5'd13: r = ANG_W'(32'h0001FFFF);
      5'd14: r = ANG_W'(32'h0000FFFF);
      5'd15: r = ANG_W'(32'h00007FFF);
      5'd16: r = ANG_W'(32'h00003FFF);
      5'd17: r = ANG_W'(32'h00001FFF);
      5'd18: r = ANG_W'(32'h00000FFF);
      5'd19: r = ANG_W'(32'h000007FF);
      5'd20: r = ANG_W'(32'h000003FF);
      5'd21: r = ANG_W'(32'h000001FF);
      5'd22: r = ANG_W'(32'h000000FF);
      5'd23: r = ANG_W'(32'h0000007F);
      5'd24: r = ANG_W'(32'h0000003F);
      5'd25: r = ANG_W'(32'h0000001F);
      5'd26: r = ANG_W'(32'h0000000F);
      5'd27: r = ANG_W'(32'h00000008);
      5'd28: r = ANG_W'(32'h00000004);
      5'd29: r = ANG_W'(32'h00000002);
      5'd30: r = ANG_W'(32'h00000001);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/pip_ctrl.sv @@
module pip_ctrl import pip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       command,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t            state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  res_kind_t         res_q, res_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      res_q <= RES_NONE;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      res_q <= res_q_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    res_q_next = res_q;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.idx    = cnt;
    cmd.res    = res_q;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == CMD_LOAD) begin
            cmd.op = OP_LOAD;
          end else begin
            cmd.op = OP_QSTART;
            if (status.cnt_zero) begin
              res_q_next = RES_SUM;
              state_next = ST_OUT;
            end else if (status.cnt_one) begin
              res_q_next = RES_NONE;
              state_next = ST_OUT;
            end else begin
              state_next = ST_RD0;
            end
          end
        end
      end
      ST_RD0: begin
        cmd.op     = OP_READ0;
        state_next = ST_LDA;
      end
      ST_LDA: begin
        cmd.op     = OP_LDA;
        state_next = ST_RDJ;
      end
      ST_RDJ: begin
        cmd.op     = OP_READJ;
        state_next = ST_LDB;
      end
      ST_LDB: begin
        cmd.op     = OP_LDB;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.op     = OP_DIFF;
        cnt_next   = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.op = OP_MUL;
        if (cnt == STEP_W'(MUL_STEPS)) begin
          state_next = ST_VTEST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_VTEST: begin
        if (status.vertex_hit) begin
          res_q_next = RES_VERTEX;
          state_next = ST_OUT;
        end else begin
          state_next = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        cmd.op     = OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt == STEP_W'(ROOT_W - 1)) begin
          state_next = ST_MULC;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_MULC: begin
        cmd.op     = OP_MULC;
        state_next = ST_ETEST;
      end
      ST_ETEST: begin
        if (status.edge_hit) begin
          res_q_next = RES_EDGE;
          state_next = ST_OUT;
        end else begin
          state_next = ST_NORM_INIT;
        end
      end
      ST_NORM_INIT: begin
        cmd.op     = OP_NORM_INIT;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        if (status.ang_zero) begin
          state_next = ST_ACC;
        end else if (status.norm_done) begin
          state_next = ST_CORD_INIT;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      ST_CORD_INIT: begin
        cmd.op     = OP_CORD_INIT;
        cnt_next   = '0;
        state_next = ST_CORD;
      end
      ST_CORD: begin
        cmd.op = OP_CORD;
        if (cnt == STEP_W'(CORD_STEPS - 1)) begin
          state_next = ST_ACC;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_ACC: begin
        cmd.op = OP_ACC;
        if (status.last_edge) begin
          res_q_next = RES_SUM;
          state_next = ST_OUT;
        end else begin
          state_next = ST_RDJ;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.op     = OP_RESULT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/pip_dp.sv @@
module pip_dp import pip_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  dp_cmd_t                      cmd,
  output dp_status_t                   status,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic                         last_vertex,
  input  logic                         cfg_valid,
  input  logic [EPS_W-1:0]             cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         inside_res,
  output logic                         on_vertex,
  output logic                         on_edge
);

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] rdx, rdy, px, py, ax, ay, bx, by;
  logic [CNT_W-1:0]             count, base_count;
  logic                         closed;
  logic [ADDR_W-1:0]            edge_idx, jaddr, raddr;
  logic                         wr_en;
  logic [EPS_W-1:0]             eps;
  logic [2*EPS_W-1:0]           eps_sq;

  logic signed [DIFF_W-1:0]     ux, uy, wx, wy, ex, ey;
  logic signed [MUL_W-1:0]      ma, mb;
  logic signed [PROD_W-1:0]     prod, tmp, mul_out, pair_val;
  logic [3:0]                   sel;
  logic [STEP_W-1:0]            pidx;
  logic signed [ACC_W-1:0]      a2, b2, ue, we, cr, c2, dt;
  logic [ACC_W-1:0]             cr_abs, dt_abs;

  logic [ACC_W-1:0]             sq_n;
  logic [REM_W-1:0]             rem, rem_t, trial;
  logic [ROOT_W-1:0]            root;

  logic [ACC_W-1:0]             nm, ny, orv;
  logic                         dneg;
  logic signed [CRD_W-1:0]      cx, cy, sx, sy;
  logic signed [ANG_W-1:0]      cz;
  logic signed [SUM_W-1:0]      sum;
  logic signed [SUM_W:0]        dsum;
  logic [SUM_W:0]               adiff;
  logic                         sum_in;

  assign base_count = closed ? '0 : count;
  assign wr_en      = (cmd.op == OP_LOAD) && (base_count < CNT_W'(MAX_VERTICES));
  assign status.last_edge = (CNT_W'(edge_idx) + 1'b1) == count;
  assign jaddr = status.last_edge ? '0 : edge_idx + 1'b1;
  assign raddr = (cmd.op == OP_READ0) ? '0 : jaddr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[base_count[ADDR_W-1:0]] <= coord_x;
      mem_y[base_count[ADDR_W-1:0]] <= coord_y;
    end
    rdx <= mem_x[raddr];
    rdy <= mem_y[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      closed    <= 1'b0;
      eps       <= EPS_W'(7);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        eps <= cfg_data;
      end
      if (cmd.op == OP_LOAD) begin
        closed <= last_vertex;
        count  <= wr_en ? base_count + 1'b1 : base_count;
      end
      if (cmd.op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sel  = (cmd.op == OP_MULC) ? SEL_EPS_ROOT : cmd.idx[3:0];
    ma   = MUL_W'(ux);
    mb   = MUL_W'(ux);
    case (sel)
      4'd0:  begin ma = MUL_W'(ux); mb = MUL_W'(ux); end
      4'd1:  begin ma = MUL_W'(uy); mb = MUL_W'(uy); end
      4'd2:  begin ma = MUL_W'(wx); mb = MUL_W'(wx); end
      4'd3:  begin ma = MUL_W'(wy); mb = MUL_W'(wy); end
      4'd4:  begin ma = MUL_W'(ux); mb = MUL_W'(ex); end
      4'd5:  begin ma = MUL_W'(uy); mb = MUL_W'(ey); end
      4'd6:  begin ma = MUL_W'(wx); mb = MUL_W'(ex); end
      4'd7:  begin ma = MUL_W'(wy); mb = MUL_W'(ey); end
      4'd8:  begin ma = MUL_W'(ux); mb = MUL_W'(wy); end
      4'd9:  begin ma = MUL_W'(uy); mb = MUL_W'(wx); end
      4'd10: begin ma = MUL_W'(ex); mb = MUL_W'(ex); end
      4'd11: begin ma = MUL_W'(ey); mb = MUL_W'(ey); end
      4'd12: begin ma = MUL_W'(ux); mb = MUL_W'(wx); end
      4'd13: begin ma = MUL_W'(uy); mb = MUL_W'(wy); end
      SEL_EPS_ROOT: begin
        ma = MUL_W'($signed({1'b0, eps}));
        mb = $signed({1'b0, root});
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign mul_out  = ma * mb;
  assign pidx     = cmd.idx - 1'b1;
  assign pair_val = (pidx[3:1] == PAIR_CR) ? tmp - prod : tmp + prod;

  assign cr_abs = cr[ACC_W-1] ? $unsigned(-cr) : $unsigned(cr);
  assign dt_abs = dt[ACC_W-1] ? $unsigned(-dt) : $unsigned(dt);

  assign rem_t = {rem[REM_W-3:0], sq_n[ACC_W-1 -: 2]};
  assign trial = {root, 2'b01};

  assign orv = nm | ny;
  assign sx  = cy >>> cmd.idx[4:0];
  assign sy  = cx >>> cmd.idx[4:0];

  assign dsum   = (SUM_W + 1)'(sum) - TWO_PI_Q30;
  assign adiff  = dsum[SUM_W] ? $unsigned(-dsum) : $unsigned(dsum);
  assign sum_in = adiff < (SUM_W + 1)'({eps, EPS_SHIFT'(0)});

  always_ff @(posedge clk) begin
    eps_sq <= eps * eps;
    case (cmd.op)
      OP_QSTART: begin
        px       <= coord_x;
        py       <= coord_y;
        sum      <= '0;
        edge_idx <= '0;
      end
      OP_LDA: begin
        ax <= rdx;
        ay <= rdy;
      end
      OP_LDB: begin
        bx <= rdx;
        by <= rdy;
      end
      OP_DIFF: begin
        ux <= DIFF_W'(ax) - DIFF_W'(px);
        uy <= DIFF_W'(ay) - DIFF_W'(py);
        wx <= DIFF_W'(bx) - DIFF_W'(px);
        wy <= DIFF_W'(by) - DIFF_W'(py);
        ex <= DIFF_W'(bx) - DIFF_W'(ax);
        ey <= DIFF_W'(by) - DIFF_W'(ay);
      end
      OP_MUL: begin
        if (cmd.idx < STEP_W'(MUL_STEPS)) begin
          prod <= mul_out;
        end
        if (cmd.idx != '0) begin
          if (!pidx[0]) begin
            tmp <= prod;
          end else begin
            case (pidx[3:1])
              PAIR_A2:  a2 <= ACC_W'(pair_val);
              PAIR_B2:  b2 <= ACC_W'(pair_val);
              PAIR_UE:  ue <= ACC_W'(pair_val);
              PAIR_WE:  we <= ACC_W'(pair_val);
              PAIR_CR:  cr <= ACC_W'(pair_val);
              PAIR_C2:  c2 <= ACC_W'(pair_val);
              PAIR_DOT: dt <= ACC_W'(pair_val);
              default:  tmp <= prod;
            endcase
          end
        end
      end
      OP_SQRT_INIT: begin
        sq_n <= c2;
        rem  <= '0;
        root <= '0;
      end
      OP_SQRT: begin
        sq_n <= sq_n << 2;
        if (rem_t >= trial) begin
          rem  <= rem_t - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_t;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      OP_MULC: begin
        prod <= mul_out;
      end
      OP_NORM_INIT: begin
        nm   <= dt_abs;
        ny   <= cr_abs;
        dneg <= dt[ACC_W-1];
        cz   <= '0;
      end
      OP_NORM: begin
        if (|orv[ACC_W-1:NORM_BITS]) begin
          nm <= nm >> 1;
          ny <= ny >> 1;
        end else begin
          nm <= nm << 1;
          ny <= ny << 1;
        end
      end
      OP_CORD_INIT: begin
        if (dneg) begin
          cx <= CRD_W'($signed({1'b0, ny[NORM_BITS-1:0]}));
          cy <= CRD_W'($signed({1'b0, nm[NORM_BITS-1:0]}));
          cz <= HALF_PI_Q30;
        end else begin
          cx <= CRD_W'($signed({1'b0, nm[NORM_BITS-1:0]}));
          cy <= CRD_W'($signed({1'b0, ny[NORM_BITS-1:0]}));
          cz <= '0;
        end
      end
      OP_CORD: begin
        if (cy > 0) begin
          cx <= cx + sx;
          cy <= cy - sy;
          cz <= cz + $signed(atan_q30(cmd.idx[4:0]));
        end else if (cy < 0) begin
          cx <= cx - sx;
          cy <= cy + sy;
          cz <= cz - $signed(atan_q30(cmd.idx[4:0]));
        end
      end
      OP_ACC: begin
        sum      <= sum + SUM_W'(cz);
        ax       <= bx;
        ay       <= by;
        edge_idx <= edge_idx + 1'b1;
      end
      OP_RESULT: begin
        case (cmd.res)
          RES_VERTEX: begin inside_res <= 1'b1; on_vertex <= 1'b1; on_edge <= 1'b0; end
          RES_EDGE:   begin inside_res <= 1'b1; on_vertex <= 1'b0; on_edge <= 1'b1; end
          RES_SUM:    begin inside_res <= sum_in; on_vertex <= 1'b0; on_edge <= 1'b0; end
          default:    begin inside_res <= 1'b0; on_vertex <= 1'b0; on_edge <= 1'b0; end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign status.cnt_zero   = count == '0;
  assign status.cnt_one    = count == CNT_W'(1);
  assign status.vertex_hit = ($unsigned(a2) < ACC_W'(eps_sq)) ||
                             ($unsigned(b2) < ACC_W'(eps_sq));
  assign status.edge_hit   = (root != '0) && (ue[ACC_W-1] || (ue == '0)) && !we[ACC_W-1] &&
                             ($signed({2'b00, cr_abs}) < prod);
  assign status.ang_zero   = orv == '0;
  assign status.norm_done  = !(|orv[ACC_W-1:NORM_BITS]) && orv[NORM_BITS-1];
  assign status.out_free   = !out_valid || out_ready;

  a_hit_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(on_vertex && on_edge))
    else $error("vertex and edge hit reported together");

  a_hit_inside: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (on_vertex || on_edge)) |-> inside_res)
    else $error("hit reported without inside");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above store size");

  a_result_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_RESULT) |=> out_valid)
    else $error("result written without valid");

endmodule

@@ rtl/point_in_polygon_angle_sum.sv @@
// A load transaction gives no result and keeps the block idle; a new item is accepted the next cycle.
// A query walks the stored edges in turn; for each edge it runs the products on the shared multiplier,
// the square root and, unless the dot and cross products are both zero, the normalization and the CORDIC iterations.
// A vertex or edge hit ends the walk early.
// Queries are handled one at a time; the result register frees the input as soon as it is written.
// Synchronous reset clears the vertex count, the closed flag and the output valid, and sets eps to 7.
module point_in_polygon_angle_sum import pip_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic                         last_vertex,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         inside_res,
  output logic                         on_vertex,
  output logic                         on_edge,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [EPS_W-1:0]             cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pip_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .last_vertex (last_vertex),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .inside_res  (inside_res),
    .on_vertex   (on_vertex),
    .on_edge     (on_edge)
  );

endmodule
